// ===== src/plru_pkg.sv =====
// Shared types and constants for the partitioned LRU victim selector.
// Used by every module of the block except the checker; depends on nothing.
package plru_pkg;

	// Fixed widths of the request and result fields.
	localparam int FieldWays  = 8;
	localparam int OwnerBits  = 2;
	localparam int AgeBits    = 3;
	localparam int WayBits    = 3;
	localparam int NumCoreIds = 4;
	localparam int AllocBits  = 4;
	localparam int CountBits  = 4;

	// Allocation register reset value.
	localparam logic [AllocBits-1:0] AllocReset = 4'd2;

	typedef logic [AllocBits-1:0] alloc_t;
	typedef alloc_t [NumCoreIds-1:0] alloc_vec_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_ALLOC_CORE0 = 2'd0,
		REG_ALLOC_CORE1 = 2'd1,
		REG_ALLOC_CORE2 = 2'd2,
		REG_ALLOC_CORE3 = 2'd3
	} reg_idx_t;

	// Outcome of one victim decision.
	typedef struct packed {
		logic [WayBits-1:0] way;
		logic               found;
		logic               free_way;
	} victim_t;

endpackage

// ===== src/partitioned_lru_victim_select.sv =====
// Top level of the partitioned LRU victim selector: input register, decision
// logic and result register. Depends on plru_pkg, plru_alloc_regs, plru_pick.
//
//  channel   handshake              words
//  request   start, busy            way_valid_mask, way_owner_map, way_age_map, req_core
//  result    strobe                 victim_way, victim_found, took_free_way
//  config    cfg_wr_en              cfg_index, cfg_data
//
// One request word is taken every cycle; busy is always low.
// A result appears on the strobe once its request has passed through the
// input register and then through the decision logic into the result
// register. Reset clears the pipeline valid flags and sets every
// allocation to two ways. The receiver cannot stall, so nothing holds back.
module partitioned_lru_victim_select #(
	parameter int WAYS  = 8,
	parameter int CORES = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [7:0]               way_valid_mask,
	input  logic [15:0]              way_owner_map,
	input  logic [23:0]              way_age_map,
	input  logic [1:0]               req_core,
	output logic                     strobe,
	output logic [2:0]               victim_way,
	output logic                     victim_found,
	output logic                     took_free_way,
	input  logic                     cfg_wr_en,
	input  logic [1:0]               cfg_index,
	input  logic [3:0]               cfg_data
);

	plru_pkg::alloc_vec_t alloc;
	plru_pkg::victim_t    victim;

	logic        valid_s1;
	logic [7:0]  mask_s1;
	logic [15:0] owners_s1;
	logic [23:0] ages_s1;
	logic [1:0]  req_s1;

	logic              strobe_s2;
	plru_pkg::victim_t victim_s2;

	assign busy = 1'b0;

	plru_alloc_regs u_alloc (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.alloc     (alloc)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			mask_s1   <= way_valid_mask;
			owners_s1 <= way_owner_map;
			ages_s1   <= way_age_map;
			req_s1    <= req_core;
		end
	end

	plru_pick #(
		.WAYS  (WAYS),
		.CORES (CORES)
	) u_pick (
		.valid  (mask_s1),
		.owners (owners_s1),
		.ages   (ages_s1),
		.req    (req_s1),
		.alloc  (alloc),
		.victim (victim)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_s2 <= 1'b0;
		end else begin
			strobe_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		victim_s2 <= victim;
	end

	assign strobe        = strobe_s2;
	assign victim_way    = victim_s2.way;
	assign victim_found  = victim_s2.found;
	assign took_free_way = victim_s2.free_way;

endmodule

// ===== src/plru_alloc_regs.sv =====
// Per-core way allocation registers written through the configuration port.
// Depends on plru_pkg.
module plru_alloc_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [1:0]           cfg_index,
	input  plru_pkg::alloc_t     cfg_data,
	output plru_pkg::alloc_vec_t alloc
);

	plru_pkg::alloc_vec_t alloc_q;

	// One register per core, selected by index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < plru_pkg::NumCoreIds; c++) begin
				alloc_q[c] <= plru_pkg::AllocReset;
			end
		end else if (cfg_wr_en) begin
			case (plru_pkg::reg_idx_t'(cfg_index))
				plru_pkg::REG_ALLOC_CORE0: alloc_q[0] <= cfg_data;
				plru_pkg::REG_ALLOC_CORE1: alloc_q[1] <= cfg_data;
				plru_pkg::REG_ALLOC_CORE2: alloc_q[2] <= cfg_data;
				plru_pkg::REG_ALLOC_CORE3: alloc_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign alloc = alloc_q;

endmodule

// ===== src/plru_pick.sv =====
// Combinational victim decision for one set snapshot.
// Depends on plru_pkg; instantiated between the input and result registers.
module plru_pick #(
	parameter int WAYS  = 8,
	parameter int CORES = 4
) (
	input  logic [7:0]           valid,
	input  logic [15:0]          owners,
	input  logic [23:0]          ages,
	input  logic [1:0]           req,
	input  plru_pkg::alloc_vec_t alloc,
	output plru_pkg::victim_t    victim
);

	// Ways that have bits in the fields; any way above them is always invalid.
	localparam int  LowWays = (WAYS < plru_pkg::FieldWays) ? WAYS : plru_pkg::FieldWays;
	localparam bit  HasHigh = (WAYS > plru_pkg::FieldWays);

	logic [plru_pkg::NumCoreIds-1:0][plru_pkg::CountBits-1:0] held;
	plru_pkg::alloc_vec_t                                     eff_alloc;
	logic                                                     free_hit;
	logic [plru_pkg::WayBits-1:0]                             free_idx;
	logic                                                     req_below;
	logic                                                     best_found;
	logic [plru_pkg::WayBits-1:0]                             best_way;
	logic [plru_pkg::AgeBits-1:0]                             best_age;

	// Count ways per owner and apply the core limit to the allocations.
	always_comb begin
		logic [1:0] own;
		held = '0;
		for (int w = 0; w < LowWays; w++) begin
			own = owners[plru_pkg::OwnerBits*w +: plru_pkg::OwnerBits];
			held[own] = held[own] + 4'd1;
		end
		for (int c = 0; c < plru_pkg::NumCoreIds; c++) begin
			eff_alloc[c] = (c < CORES) ? alloc[c] : '0;
		end
	end

	// First invalid way, scanned from the top so the lowest one is kept.
	always_comb begin
		free_hit = HasHigh;
		free_idx = '0;
		for (int w = LowWays - 1; w >= 0; w--) begin
			if (!valid[w]) begin
				free_hit = 1'b1;
				free_idx = plru_pkg::WayBits'(w);
			end
		end
	end

	// Oldest eligible way; a strict compare keeps the first way on a tie.
	always_comb begin
		logic [1:0]                   own;
		logic [plru_pkg::AgeBits-1:0] age;
		logic                         elig;
		req_below  = held[req] < eff_alloc[req];
		best_found = 1'b0;
		best_way   = '0;
		best_age   = '0;
		for (int w = 0; w < LowWays; w++) begin
			own = owners[plru_pkg::OwnerBits*w +: plru_pkg::OwnerBits];
			age = ages[plru_pkg::AgeBits*w +: plru_pkg::AgeBits];
			if (req_below) begin
				elig = (own != req) && (held[own] >= eff_alloc[own]);
			end else begin
				elig = (own == req);
			end
			if (elig && (!best_found || age < best_age)) begin
				best_found = 1'b1;
				best_way   = plru_pkg::WayBits'(w);
				best_age   = age;
			end
		end
	end

	// A free way overrides the replacement choice.
	always_comb begin
		if (free_hit) begin
			victim.way      = free_idx;
			victim.found    = 1'b1;
			victim.free_way = 1'b1;
		end else begin
			victim.way      = best_found ? best_way : '0;
			victim.found    = best_found;
			victim.free_way = 1'b0;
		end
	end

endmodule

// ===== src/plru_checker.sv =====
// Port-level checks for the partitioned LRU victim selector, and the bind
// that attaches them to the top level. Depends on the top level's ports only.
module plru_checker #(
	parameter int WAYS = 8
) (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [7:0]  way_valid_mask,
	input logic        strobe,
	input logic [2:0]  victim_way,
	input logic        victim_found,
	input logic        took_free_way
);

	localparam bit HasHigh = (WAYS > 8);
	localparam int LowWays = (WAYS < 8) ? WAYS : 8;
	localparam logic [7:0] LowMask = 8'((16'd1 << LowWays) - 16'd1);

	// Every accepted word yields a result through the input and result registers.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 strobe)
		else $error("accepted word produced no result");

	// No result without an accepted word behind it.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(start && !busy, 2))
		else $error("result without an accepted word");

	// An empty result carries zero way and no free flag.
	a_none_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !victim_found) |-> (victim_way == 3'd0 && !took_free_way))
		else $error("no-victim result not clean");

	// A free way is taken exactly when the snapshot had an invalid way.
	a_free_match: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (took_free_way ==
			(HasHigh || (($past(way_valid_mask, 2) & LowMask) != LowMask))))
		else $error("free-way flag does not match valid mask");

	// A free way is always a found victim.
	a_free_found: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && took_free_way) |-> victim_found)
		else $error("free way taken without victim_found");

endmodule

bind partitioned_lru_victim_select plru_checker #(
	.WAYS (WAYS)
) u_plru_checker (.*);

// ===== test/tb_partitioned_lru_victim_select.sv =====
// Self-checking testbench for the partitioned LRU victim selector.
// Predicts each victim decision from the set snapshot and the allocation registers.
// Depends on plru_pkg and partitioned_lru_victim_select.
module tb_partitioned_lru_victim_select;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        start          = 1'b0;
	logic        busy;
	logic [7:0]  way_valid_mask = '0;
	logic [15:0] way_owner_map  = '0;
	logic [23:0] way_age_map    = '0;
	logic [1:0]  req_core       = '0;
	logic        strobe;
	logic [2:0]  victim_way;
	logic        victim_found;
	logic        took_free_way;
	logic        cfg_wr_en      = 1'b0;
	logic [1:0]  cfg_index      = '0;
	logic [3:0]  cfg_data       = '0;

	// Decisions still owed by the block, oldest first.
	plru_pkg::victim_t    pending_victims[$];
	// Our own copy of the allocation registers.
	plru_pkg::alloc_vec_t core_alloc_ways = {plru_pkg::NumCoreIds{plru_pkg::AllocReset}};
	int                   error_count     = 0;
	bit                   idle_on         = 1'b1;

	partitioned_lru_victim_select DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.way_valid_mask (way_valid_mask),
		.way_owner_map  (way_owner_map),
		.way_age_map    (way_age_map),
		.req_core       (req_core),
		.strobe         (strobe),
		.victim_way     (victim_way),
		.victim_found   (victim_found),
		.took_free_way  (took_free_way),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Victim choice for one set snapshot under the given allocations.
	function automatic plru_pkg::victim_t pick_victim(input logic [7:0] valid,
			input logic [15:0] owners, input logic [23:0] ages, input logic [1:0] req,
			input plru_pkg::alloc_vec_t alloc);
		int unsigned                    held [plru_pkg::NumCoreIds];
		logic [plru_pkg::OwnerBits-1:0] own;
		logic [plru_pkg::AgeBits-1:0]   age;
		logic [plru_pkg::AgeBits-1:0]   best_age;
		logic                           below;
		logic                           eligible;
		plru_pkg::victim_t              v;
		v        = '0;
		best_age = '0;
		for (int c = 0; c < plru_pkg::NumCoreIds; c++)
			held[c] = 0;
		// Every way counts toward its owner, valid or not.
		for (int w = 0; w < plru_pkg::FieldWays; w++)
			held[owners[plru_pkg::OwnerBits*w +: plru_pkg::OwnerBits]]++;
		// The first invalid way wins outright.
		for (int w = 0; w < plru_pkg::FieldWays; w++) begin
			if (!v.free_way && !valid[w]) begin
				v.way      = plru_pkg::WayBits'(w);
				v.found    = 1'b1;
				v.free_way = 1'b1;
			end
		end
		// Full set: oldest eligible way, lowest index on a tie.
		if (!v.free_way) begin
			below = held[req] < alloc[req];
			for (int w = 0; w < plru_pkg::FieldWays; w++) begin
				own = owners[plru_pkg::OwnerBits*w +: plru_pkg::OwnerBits];
				age = ages[plru_pkg::AgeBits*w +: plru_pkg::AgeBits];
				if (below)
					eligible = (own != req) && (held[own] >= alloc[own]);
				else
					eligible = (own == req);
				if (eligible && (!v.found || age < best_age)) begin
					v.found  = 1'b1;
					v.way    = plru_pkg::WayBits'(w);
					best_age = age;
				end
			end
		end
		return v;
	endfunction

	// Check each result word, then record the request word taken at this edge.
	always @(posedge clk) begin : result_check
		plru_pkg::victim_t want;
		if (arst_n) begin
			if (strobe) begin
				if (pending_victims.size() == 0) begin
					$error("result word with no request pending: victim_way %0d", victim_way);
					error_count++;
				end else begin
					want = pending_victims.pop_front();
					if (victim_way !== want.way) begin
						$error("victim_way expected %0d actual %0d", want.way, victim_way);
						error_count++;
					end
					if (victim_found !== want.found) begin
						$error("victim_found expected %0b actual %0b", want.found, victim_found);
						error_count++;
					end
					if (took_free_way !== want.free_way) begin
						$error("took_free_way expected %0b actual %0b", want.free_way,
							took_free_way);
						error_count++;
					end
				end
			end
			if (start && !busy)
				pending_victims.push_back(pick_victim(way_valid_mask, way_owner_map,
					way_age_map, req_core, core_alloc_ways));
			if (cfg_wr_en)
				core_alloc_ways[cfg_index] = cfg_data;
		end
	end

	// Send one request word, with random idle cycles ahead of it.
	task automatic send_word(input logic [7:0] valid, input logic [15:0] owners,
			input logic [23:0] ages, input logic [1:0] req);
		while (idle_on && $urandom_range(0, 99) < 32) begin
			start          <= 1'b0;
			way_valid_mask <= 8'($urandom);
			way_owner_map  <= 16'($urandom);
			way_age_map    <= 24'($urandom);
			req_core       <= 2'($urandom);
			@(posedge clk);
		end
		start          <= 1'b1;
		way_valid_mask <= valid;
		way_owner_map  <= owners;
		way_age_map    <= ages;
		req_core       <= req;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Stop sending and let every owed decision come out.
	task automatic wait_idle();
		start <= 1'b0;
		while (pending_victims.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input plru_pkg::reg_idx_t idx, input plru_pkg::alloc_t value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	// Load all four allocations while the block is idle.
	task automatic set_alloc(input plru_pkg::alloc_t a0, input plru_pkg::alloc_t a1,
			input plru_pkg::alloc_t a2, input plru_pkg::alloc_t a3);
		wait_idle();
		write_reg(plru_pkg::REG_ALLOC_CORE0, a0);
		write_reg(plru_pkg::REG_ALLOC_CORE1, a1);
		write_reg(plru_pkg::REG_ALLOC_CORE2, a2);
		write_reg(plru_pkg::REG_ALLOC_CORE3, a3);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Sets with an invalid way: the first hole is taken.
	task automatic test_free_ways();
		send_word(8'h00, 16'hFFFF, 24'hFFFFFF, 2'd3);
		send_word(8'h7F, 16'h0000, 24'h000000, 2'd0);
		send_word(8'hEF, 16'hFA50, 24'h123456, 2'd1);
		send_word(8'hFE, 16'h5555, 24'hFFFFFF, 2'd2);
	endtask

	// Requester at or above its allocation: it recycles its own oldest way.
	task automatic test_own_ways();
		send_word(8'hFF, 16'h0000, 24'hFFFFFF, 2'd0);
		send_word(8'hFF, 16'hFFFF, 24'h1FFFFF, 2'd3);
		send_word(8'hFF, 16'hFA50, 24'h000000, 2'd2);
		send_word(8'hFF, 16'hFA50, 24'hFFF1FF, 2'd1);
		send_word(8'hFF, 16'hAAAA, 24'hFAC688, 2'd2);
	endtask

	// Requester mostly below its allocation: it takes from cores over their share.
	task automatic test_steal();
		send_word(8'hFF, 16'h0000, 24'hFFFFFF, 2'd1);
		send_word(8'hFF, 16'h6000, 24'hFC7DFF, 2'd1);
		send_word(8'hFF, 16'hFFF0, 24'h000000, 2'd0);
		send_word(8'hFF, 16'h5F00, 24'h0FFFFF, 2'd2);
	endtask

	// Allocation extremes, including sets where no way is eligible.
	task automatic test_alloc_extremes();
		set_alloc(4'd8, 4'd8, 4'd8, 4'd8);
		send_word(8'hFF, 16'hFA50, 24'hFFFFFF, 2'd0);
		send_word(8'hFF, 16'h0000, 24'h000000, 2'd3);
		send_word(8'hFF, 16'hFFFF, 24'h123456, 2'd3);
		send_word(8'h00, 16'hFA50, 24'hFFFFFF, 2'd1);
		set_alloc(4'd0, 4'd0, 4'd0, 4'd0);
		send_word(8'hFF, 16'h0000, 24'hFFFFFF, 2'd1);
		send_word(8'hFF, 16'hFA50, 24'hFFFFC0, 2'd2);
		send_word(8'hFF, 16'hFFFF, 24'h000000, 2'd3);
		set_alloc(4'd8, 4'd0, 4'd8, 4'd0);
		send_word(8'hFF, 16'h5555, 24'hFFFFFF, 2'd0);
		send_word(8'hFF, 16'hFA50, 24'h0000FF, 2'd1);
	endtask

	// Random snapshots over several allocation settings.
	task automatic test_random(input int phases, input int words_per_phase);
		logic [7:0]  valid;
		logic [15:0] owners;
		logic [23:0] ages;
		logic [1:0]  pair_a;
		logic [1:0]  pair_b;
		for (int p = 0; p < phases; p++) begin
			if (p == 0)
				set_alloc(plru_pkg::AllocReset, plru_pkg::AllocReset, plru_pkg::AllocReset,
					plru_pkg::AllocReset);
			else if (p == 1)
				set_alloc(4'd0, 4'd8, 4'd0, 4'd8);
			else
				set_alloc(plru_pkg::alloc_t'($urandom_range(0, 8)),
					plru_pkg::alloc_t'($urandom_range(0, 8)),
					plru_pkg::alloc_t'($urandom_range(0, 8)),
					plru_pkg::alloc_t'($urandom_range(0, 8)));
			// One phase runs back to back with no idle cycles.
			idle_on = (p != 3);
			for (int i = 0; i < words_per_phase; i++) begin
				// Mostly full sets, so the partition logic decides.
				case ($urandom_range(0, 9))
					0:       valid = 8'($urandom);
					1:       valid = ~(8'h01 << $urandom_range(0, 7));
					default: valid = 8'hFF;
				endcase
				// Owners spread evenly, over two cores, or skewed toward one.
				pair_a = 2'($urandom);
				pair_b = 2'($urandom);
				case ($urandom_range(0, 2))
					0: owners = 16'($urandom);
					1: begin
						for (int w = 0; w < plru_pkg::FieldWays; w++)
							owners[2*w +: 2] = $urandom_range(0, 1) ? pair_a : pair_b;
					end
					default: begin
						for (int w = 0; w < plru_pkg::FieldWays; w++)
							owners[2*w +: 2] = ($urandom_range(0, 3) != 0) ? pair_a : 2'($urandom);
					end
				endcase
				// Narrow age ranges make ties common.
				if ($urandom_range(0, 1))
					ages = 24'($urandom);
				else begin
					for (int w = 0; w < plru_pkg::FieldWays; w++)
						ages[3*w +: 3] = 3'($urandom_range(0, 1));
				end
				send_word(valid, owners, ages, 2'($urandom));
			end
		end
		idle_on = 1'b1;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_free_ways();
		test_own_ways();
		test_steal();
		test_alloc_extremes();
		test_random(6, 100);
		wait_idle();
		repeat (4) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#1_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/plru_pkg.sv
src/plru_alloc_regs.sv
src/plru_pick.sv
src/partitioned_lru_victim_select.sv
src/plru_checker.sv
test/tb_partitioned_lru_victim_select.sv
